// ----- hw/rtl/ctc_pkg.sv -----
package ctc_pkg;

  // Field widths fixed by the interface.
  localparam int CHAR_W    = 8;
  localparam int KEYLEN_W  = 4;
  localparam int KEY_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY     = 2'd2;

  // Mode codes.
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // Byte used to fill the last row when encrypting.
  localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h78;

endpackage

// ----- hw/rtl/ctc_ram.sv -----
module ctc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- hw/rtl/columnar_transposition_cipher_unit.sv -----
// Each byte is taken in the cycle it is offered while idle; in_stall is high while busy.
// After the byte marked last: column ranking on one comparator, then repeated subtraction
// for the row count, then an address state and a data state per result byte through the
// single read port of the text buffer.
// Reset is synchronous and active low: control state clears, mode 0, key length 1, key 0.
// The text buffer holds no reset value and gets no clearing pass.
module columnar_transposition_cipher_unit
  import ctc_pkg::*;
#(
  parameter int MAX_KEY  = 8,
  parameter int MAX_TEXT = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CHAR_W-1:0]    in_char,
  input  logic                 in_last,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CHAR_W-1:0]    out_char,
  output logic                 out_last,
  output logic                 out_overflow,
  // Configuration port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CIW = $clog2(MAX_KEY);
  localparam int KW  = $clog2(MAX_KEY + 1);
  localparam int AW  = $clog2(MAX_TEXT);
  localparam int NW  = $clog2(MAX_TEXT + 1);
  localparam int CW  = $clog2(MAX_TEXT + MAX_KEY + 1);
  localparam int PW  = CIW + NW;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_RANK    = 5'b00010,
    ST_DIVIDE  = 5'b00100,
    ST_EM_ADDR = 5'b01000,
    ST_EM_DATA = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic                mode_r;
  logic [KEYLEN_W-1:0] key_len_r;
  logic [KEY_W-1:0]    key_r;

  logic [NW-1:0]  count_r;
  logic           dropped_r;
  logic [CIW-1:0] rank_r [MAX_KEY];
  logic [CIW-1:0] inv_r  [MAX_KEY];

  logic [CIW-1:0] a_r, b_r, acc_r;
  logic [CW-1:0]  rem_r, total_r;
  logic [NW-1:0]  rows_r;
  logic [CIW-1:0] p_r;
  logic [NW-1:0]  r_r;
  logic [NW-1:0]  idx_r;
  logic           pad_r, last_r, ovf_r;

  logic                out_valid_r;
  logic [CHAR_W-1:0]   out_char_r;
  logic                out_last_r, out_ovf_r;

  logic                in_acc, out_free, buf_full;
  logic [KW-1:0]       k_eff, km1;
  logic [CW-1:0]       k_cw;
  logic [CHAR_W-1:0]   la, lb;
  logic                less_w, b_end, a_end;
  logic [CIW-1:0]      acc_new, p_inc;
  logic                step_ok, cut_w;
  logic                p_end, r_end;
  logic [PW-1:0]       dec_idx;
  logic [AW-1:0]       rd_addr;
  logic [CHAR_W-1:0]   rd_data;

  // Active key length: zero counts as one, anything too big as the maximum.
  always_comb begin
    if (key_len_r == '0) begin
      k_eff = KW'(1);
    end else if (key_len_r > KEYLEN_W'(MAX_KEY)) begin
      k_eff = KW'(MAX_KEY);
    end else begin
      k_eff = KW'(key_len_r);
    end
  end
  assign km1  = k_eff - KW'(1);
  assign k_cw = CW'(k_eff);

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign buf_full = (count_r == NW'(MAX_TEXT));

  // Ranking compare: column b goes before column a on a lower letter, or the same
  // letter at a lower position.
  assign la      = key_r[8*a_r +: 8];
  assign lb      = key_r[8*b_r +: 8];
  assign less_w  = (lb < la) || ((lb == la) && (b_r < a_r));
  assign acc_new = acc_r + CIW'(less_w);
  assign b_end   = (KW'(b_r) == km1);
  assign a_end   = (KW'(a_r) == km1);

  // Row count by repeated subtraction, stopping early if the buffer would overflow.
  assign step_ok = (rem_r >= k_cw) && ((total_r + k_cw) <= CW'(MAX_TEXT));
  assign cut_w   = (rem_r >= k_cw);

  // Emission indexes.
  assign p_end   = (KW'(p_r) == km1);
  assign r_end   = (r_r == rows_r - NW'(1));
  assign p_inc   = p_r + CIW'(1);
  assign dec_idx = ({{NW{1'b0}}, rank_r[p_r]} * {{CIW{1'b0}}, rows_r})
                 + {{CIW{1'b0}}, r_r};
  assign rd_addr = (mode_r == MODE_ENC) ? idx_r[AW-1:0] : dec_idx[AW-1:0];

  // Text buffer.
  ctc_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_TEXT)
  ) u_text_ram (
    .clk   (clk),
    .we    (in_acc && !buf_full),
    .waddr (count_r[AW-1:0]),
    .wdata (in_char),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_last) begin
          state_nxt = ST_RANK;
        end
      end
      ST_RANK: begin
        if (b_end && a_end) begin
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (!step_ok) begin
          state_nxt = (rows_r == '0) ? ST_IDLE : ST_EM_ADDR;
        end
      end
      ST_EM_ADDR: begin
        if (out_free) begin
          state_nxt = ST_EM_DATA;
        end
      end
      ST_EM_DATA: begin
        state_nxt = last_r ? ST_IDLE : ST_EM_ADDR;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_ENC;
      key_len_r <= KEYLEN_W'(1);
      key_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:    mode_r    <= cfg_data[0];
        CFG_KEY_LEN: key_len_r <= cfg_data[KEYLEN_W-1:0];
        CFG_KEY:     key_r     <= cfg_data[KEY_W-1:0];
        default:     ;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (buf_full) begin
              dropped_r <= 1'b1;
            end else begin
              count_r <= count_r + NW'(1);
            end
          end
        end
        ST_DIVIDE: begin
          if (!step_ok && rows_r == '0) begin
            count_r   <= '0;
            dropped_r <= 1'b0;
          end
        end
        ST_EM_DATA: begin
          out_valid_r <= 1'b1;
          if (last_r) begin
            count_r   <= '0;
            dropped_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        a_r   <= '0;
        b_r   <= '0;
        acc_r <= '0;
      end
      ST_RANK: begin
        if (b_end) begin
          rank_r[a_r]    <= acc_new;
          inv_r[acc_new] <= a_r;
          acc_r          <= '0;
          b_r            <= '0;
          a_r            <= a_r + CIW'(1);
        end else begin
          acc_r <= acc_new;
          b_r   <= b_r + CIW'(1);
        end
        // Set up the row count for the divide pass.
        rem_r   <= (mode_r == MODE_ENC) ? (CW'(count_r) + k_cw - CW'(1)) : CW'(count_r);
        total_r <= '0;
        rows_r  <= '0;
      end
      ST_DIVIDE: begin
        if (step_ok) begin
          rem_r   <= rem_r - k_cw;
          total_r <= total_r + k_cw;
          rows_r  <= rows_r + NW'(1);
        end else begin
          ovf_r <= dropped_r || cut_w;
          p_r   <= '0;
          r_r   <= '0;
          idx_r <= NW'(inv_r[0]);
        end
      end
      ST_EM_ADDR: begin
        if (out_free) begin
          pad_r  <= (mode_r == MODE_ENC) && (idx_r >= count_r);
          last_r <= p_end && r_end;
          if (mode_r == MODE_ENC) begin
            // Down one column, then on to the next column in rank order.
            if (r_end) begin
              r_r   <= '0;
              p_r   <= p_inc;
              idx_r <= NW'(inv_r[p_inc]);
            end else begin
              r_r   <= r_r + NW'(1);
              idx_r <= idx_r + NW'(k_eff);
            end
          end else begin
            // Across one row, then on to the next row.
            if (p_end) begin
              p_r <= '0;
              r_r <= r_r + NW'(1);
            end else begin
              p_r <= p_inc;
            end
          end
        end
      end
      ST_EM_DATA: begin
        out_char_r <= pad_r ? PAD_CHAR : rd_data;
        out_last_r <= last_r;
        out_ovf_r  <= ovf_r;
      end
      default: ;
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_char     = out_char_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

endmodule

// ----- hw/rtl/ctc_chk.sv -----
module ctc_chk
  import ctc_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 in_last,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [CHAR_W-1:0]    out_char,
  input logic                 out_last,
  input logic                 out_overflow
);

  // After reset the block is empty and ready.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // A stalled result request keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(out_last)
                               && $stable(out_overflow))
    else $error("stalled result changed");

  // The closing byte of a message makes the block busy.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> in_stall)
    else $error("input taken straight after the closing byte");

  // Results only appear while the block is busy emitting.
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while the block was idle");

endmodule

bind columnar_transposition_cipher_unit ctc_chk u_ctc_chk (.*);
